// File: hw/rtl/svpd_pkg.sv
// ----------------------------------------------------------------------------
// svpd_pkg
// Shared types and constants of the space vector PWM duty core: fixed-point
// constants, constant reciprocals, pipeline stage map and stage record.
// ----------------------------------------------------------------------------
package svpd_pkg;

    // Q1.15 unity
    localparam logic [15:0] Q15_ONE = 16'h8000;

    // pi/3 in Q30
    localparam logic [30:0] PI3_Q30 = 31'd1124419809;

    // ceil(2^k/d) reciprocals, exact for 31-bit dividends
    localparam logic [31:0] RCP6    = 32'(((64'd1 << 34) + 64'd5) / 64'd6);
    localparam logic [31:0] RCP120  = 32'(((64'd1 << 38) + 64'd119) / 64'd120);
    localparam logic [31:0] RCP5040 = 32'(((64'd1 << 44) + 64'd5039) / 64'd5040);

    // sector codes
    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    // stage map
    localparam int ST_LOAD    = 0;
    localparam int ST_PREP    = 1;
    localparam int ST_SQRT0   = 2;   // 32 root stages, bit 31 first
    localparam int ST_SQRTN   = 33;
    localparam int ST_SIN_X2  = 2;
    localparam int ST_SIN_X3  = 3;
    localparam int ST_SIN_X5  = 4;
    localparam int ST_SIN_X7  = 5;
    localparam int ST_SIN_Q7  = 6;
    localparam int ST_SIN_SUM = 7;
    localparam int ST_SRCH0   = 34;  // overflow check
    localparam int ST_SRCHN   = 49;  // last of 15 index-bit stages
    localparam int ST_SCALE   = 50;
    localparam int ST_DUTY    = 51;
    localparam int NS         = 52;

    // one sine lane, Q30
    typedef struct packed {
        logic [16:0] u;
        logic [30:0] x;
        logic [30:0] x2;
        logic [30:0] x3;
        logic [30:0] x5;
        logic [30:0] x7;
        logic [30:0] q3;
        logic [30:0] q5;
        logic [30:0] q7;
        logic [30:0] sn;
    } t_lane;

    // stage record
    typedef struct packed {
        logic [15:0] bus;
        logic [2:0]  sec;
        logic [31:0] aa;
        logic [31:0] bb;
        logic [63:0] rem;
        logic [31:0] root;
        t_lane [1:0] ln;     // lane 0: T1 sine, lane 1: T2 sine
        logic        full;
        logic [31:0] acc;
        logic [15:0] m;
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] da;
        logic [15:0] db;
        logic [15:0] dc;
    } t_item;

endpackage

// File: hw/rtl/svpd_in_if.sv
// ----------------------------------------------------------------------------
// svpd_in_if
// Request channel of the duty core: voltage vector, angle and bus voltage.
// ----------------------------------------------------------------------------
interface svpd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
    logic [15:0]        angle;
    logic [15:0]        bus_voltage;

    modport source (output valid, v_alpha, v_beta, angle, bus_voltage, input ready);
    modport sink   (input valid, v_alpha, v_beta, angle, bus_voltage, output ready);
endinterface

// File: hw/rtl/svpd_out_if.sv
// ----------------------------------------------------------------------------
// svpd_out_if
// Result channel of the duty core: sector, index and per-phase duties.
// ----------------------------------------------------------------------------
interface svpd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  sector;
    logic [15:0] mod_index;
    logic [15:0] duty_a_high;
    logic [15:0] duty_a_low;
    logic [15:0] duty_b_high;
    logic [15:0] duty_b_low;
    logic [15:0] duty_c_high;
    logic [15:0] duty_c_low;

    modport source (output valid, sector, mod_index, duty_a_high, duty_a_low,
                    duty_b_high, duty_b_low, duty_c_high, duty_c_low, input ready);
    modport sink   (input valid, sector, mod_index, duty_a_high, duty_a_low,
                    duty_b_high, duty_b_low, duty_c_high, duty_c_low, output ready);
endinterface

// File: hw/rtl/space_vector_pwm_duty_core.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_core
// Three-phase space vector modulation duty generator, elastic pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request per transfer (v_alpha, v_beta, angle,
//   bus_voltage); o_out returns one result per request, in order: sector,
//   modulation index and high/low duties of phases A, B and C in Q1.15.
//   A transfer happens when valid and ready are both high.
//   A new request can enter every cycle while the receiver takes results,
//   so sustained throughput is then one per cycle.
//   The depth is set by the square-root unit (one root bit per stage, 32
//   stages) followed by the 16-stage index search.
//   Each stage holds one item with its own valid bit; when the receiver
//   stalls, the result stays on o_out and earlier stages keep filling empty
//   slots, so i_in.ready stays high until the pipe is full. Nothing is lost
//   or repeated.
//   Reset (i_rst_n low, synchronous) empties all stages; no clearing pass.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_core
    import svpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    svpd_in_if.sink    i_in,
    svpd_out_if.source o_out
);

    logic        r_v [NS];
    t_item       r_d [NS];
    t_item       n_d [NS];
    logic [NS:0] rdy;

    // doubled duty T0 + 2X limited to [0, 2.0], then halved
    function automatic logic [15:0] f_duty(logic signed [19:0] t0, logic [19:0] x);
        logic signed [19:0] d2;
        d2 = t0 + signed'(x << 1);
        if (d2 < 0) begin
            d2 = '0;
        end else if (d2 > 20'sd65536) begin
            d2 = 20'sd65536;
        end
        return 16'(d2 >>> 1);
    endfunction

    // ready chain: a stage loads when empty or when its item moves on
    always_comb begin
        rdy[NS] = o_out.ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !r_v[i] || rdy[i+1];
        end
    end

    assign i_in.ready = rdy[0];

    // per-stage datapath
    always_comb begin
        t_item              cur;
        logic [18:0]        p;
        logic [32:0]        sum;
        logic [63:0]        trial;
        logic [32:0]        cand;
        logic signed [19:0] t0;
        logic [19:0]        x1;
        logic [19:0]        x2;
        logic [19:0]        x12;
        logic [19:0]        xa;
        logic [19:0]        xb;
        logic [19:0]        xc;
        int                 k;
        for (int i = 0; i < NS; i++) begin
            cur = (i == 0) ? '0 : r_d[(i == 0) ? 0 : i - 1];
            p = '0; sum = '0; trial = '0; cand = '0;
            t0 = '0; x1 = '0; x2 = '0; x12 = '0; xa = '0; xb = '0; xc = '0;
            k = 0;

            // squares, sector and in-sector position
            if (i == ST_LOAD) begin
                cur.bus = i_in.bus_voltage;
                cur.aa  = 32'(i_in.v_alpha * i_in.v_alpha);
                cur.bb  = 32'(i_in.v_beta * i_in.v_beta);
                p       = 19'(i_in.angle) * 19'd6;
                cur.sec = p[18:16];
                cur.ln[1].u = {1'b0, p[15:0]};
                cur.ln[0].u = 17'h10000 - {1'b0, p[15:0]};
            end

            // radicand 3*|V|^2*2^30 and sine arguments
            if (i == ST_PREP) begin
                sum      = 33'(cur.aa) + 33'(cur.bb);
                cur.rem  = (64'(sum) * 64'd3) << 30;
                cur.root = '0;
                for (int j = 0; j < 2; j++) begin
                    cur.ln[j].x = 31'((56'({cur.ln[j].u, 8'b0}) * 56'(PI3_Q30)) >> 24);
                end
            end

            // one root bit per stage
            if (i >= ST_SQRT0 && i <= ST_SQRTN) begin
                k     = ST_SQRTN - i;
                trial = (64'(cur.root) << (k + 1)) + (64'd1 << (2 * k));
                if (trial <= cur.rem) begin
                    cur.rem  = cur.rem - trial;
                    cur.root = cur.root | (32'd1 << k);
                end
            end

            // Taylor series, one product per lane path per stage
            for (int j = 0; j < 2; j++) begin
                if (i == ST_SIN_X2) begin
                    cur.ln[j].x2 = 31'((62'(cur.ln[j].x) * 62'(cur.ln[j].x)) >> 30);
                end
                if (i == ST_SIN_X3) begin
                    cur.ln[j].x3 = 31'((62'(cur.ln[j].x2) * 62'(cur.ln[j].x)) >> 30);
                end
                if (i == ST_SIN_X5) begin
                    cur.ln[j].x5 = 31'((62'(cur.ln[j].x3) * 62'(cur.ln[j].x2)) >> 30);
                    cur.ln[j].q3 = 31'((63'(cur.ln[j].x3) * 63'(RCP6)) >> 34);
                end
                if (i == ST_SIN_X7) begin
                    cur.ln[j].x7 = 31'((62'(cur.ln[j].x5) * 62'(cur.ln[j].x2)) >> 30);
                    cur.ln[j].q5 = 31'((63'(cur.ln[j].x5) * 63'(RCP120)) >> 38);
                end
                if (i == ST_SIN_Q7) begin
                    cur.ln[j].q7 = 31'((63'(cur.ln[j].x7) * 63'(RCP5040)) >> 44);
                end
                if (i == ST_SIN_SUM) begin
                    cur.ln[j].sn = cur.ln[j].x - cur.ln[j].q3 + cur.ln[j].q5 - cur.ln[j].q7;
                end
            end

            // index saturation check
            if (i == ST_SRCH0) begin
                cur.full = (cur.bus == '0) || ((32'(cur.bus) << 15) <= cur.root);
                cur.acc  = '0;
                cur.m    = '0;
            end

            // index bit search, acc holds m*bus
            if (i > ST_SRCH0 && i <= ST_SRCHN) begin
                k    = ST_SRCHN - i;
                cand = 33'(cur.acc) + (33'(cur.bus) << k);
                if (!cur.full && cand <= 33'(cur.root)) begin
                    cur.acc = 32'(cand);
                    cur.m   = cur.m | (16'd1 << k);
                end
            end

            // vector times
            if (i == ST_SCALE) begin
                if (cur.full) begin
                    cur.m = Q15_ONE;
                end
                cur.t1 = 16'((47'(cur.m) * 47'(cur.ln[0].sn)) >> 30);
                cur.t2 = 16'((47'(cur.m) * 47'(cur.ln[1].sn)) >> 30);
            end

            // centred duties by sector
            if (i == ST_DUTY) begin
                t0  = signed'(20'(Q15_ONE) - 20'(cur.t1) - 20'(cur.t2));
                x1  = 20'(cur.t1);
                x2  = 20'(cur.t2);
                x12 = x1 + x2;
                unique case (cur.sec)
                    SEC_0: begin xa = x12; xb = x2;  xc = '0;  end
                    SEC_1: begin xa = x1;  xb = x12; xc = '0;  end
                    SEC_2: begin xa = '0;  xb = x12; xc = x2;  end
                    SEC_3: begin xa = '0;  xb = x1;  xc = x12; end
                    SEC_4: begin xa = x2;  xb = '0;  xc = x12; end
                    default: begin xa = x12; xb = '0; xc = x1; end
                endcase
                cur.da = f_duty(t0, xa);
                cur.db = f_duty(t0, xb);
                cur.dc = f_duty(t0, xc);
            end

            n_d[i] = cur;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NS; i++) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (rdy[i]) begin
                r_v[i] <= (i == 0) ? i_in.valid : r_v[(i == 0) ? 0 : i - 1];
            end
            if (rdy[i]) begin
                r_d[i] <= n_d[i];
            end
        end
    end

    // result channel
    assign o_out.valid       = r_v[NS-1];
    assign o_out.sector      = r_d[NS-1].sec;
    assign o_out.mod_index   = r_d[NS-1].m;
    assign o_out.duty_a_high = r_d[NS-1].da;
    assign o_out.duty_a_low  = Q15_ONE - r_d[NS-1].da;
    assign o_out.duty_b_high = r_d[NS-1].db;
    assign o_out.duty_b_low  = Q15_ONE - r_d[NS-1].db;
    assign o_out.duty_c_high = r_d[NS-1].dc;
    assign o_out.duty_c_low  = Q15_ONE - r_d[NS-1].dc;

`ifndef SYNTHESIS
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && !o_out.ready) |=> r_v[NS-1])
        else $error("stalled result dropped");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.sector <= SEC_5))
        else $error("sector out of range");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.mod_index <= Q15_ONE))
        else $error("modulation index above one");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.duty_a_high <= Q15_ONE && o_out.duty_b_high <= Q15_ONE
                         && o_out.duty_c_high <= Q15_ONE))
        else $error("duty above one");

    a_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v[0]) |-> i_in.ready)
        else $error("empty entry stage refused request");
`endif

endmodule

// File: tb/space_vector_pwm_duty_core_tb.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_core_tb
// Self-checking bench for the duty core: directed corner requests, then
// random vectors with random idling on both sides, checked in order against
// a bit-exact fixed-point predictor of sector, index and phase duties.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_core_tb
    import svpd_pkg::*;
();

    typedef struct packed {
        logic signed [15:0] v_alpha;
        logic signed [15:0] v_beta;
        logic [15:0]        angle;
        logic [15:0]        bus_voltage;
    } t_req;

    typedef struct packed {
        logic [2:0]  sector;
        logic [15:0] mod_index;
        logic [15:0] a_hi;
        logic [15:0] a_lo;
        logic [15:0] b_hi;
        logic [15:0] b_lo;
        logic [15:0] c_hi;
        logic [15:0] c_lo;
    } t_duty;

    localparam int N_RANDOM   = 1080;
    localparam int TAIL_ITEMS = 150;
    localparam int LATENCY    = 52;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    svpd_in_if  req_if ();
    svpd_out_if res_if ();

    space_vector_pwm_duty_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source)
    );

    always #5 i_clk = ~i_clk;

    t_req  pending_reqs[$];
    t_duty expected_duties[$];
    int    n_errors = 0;
    int    n_checked = 0;
    int    n_sent = 0;
    int    n_total = 0;
    bit    hold_active = 1'b0;

    // (t^2 <= y * 2^30)
    function automatic bit square_fits(longint unsigned t, longint unsigned y);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = 128'(t) * 128'(t);
        rhs = 128'(y) << 30;
        return lhs <= rhs;
    endfunction

    // Q30 sine of sector fraction u / 2^16 of 60 degrees
    function automatic longint unsigned sine_q30(longint unsigned u);
        longint unsigned x, x2, x3, x5, x7;
        x  = ((u << 8) * 64'd1124419809) >> 24;
        x2 = (x * x) >> 30;
        x3 = (x2 * x) >> 30;
        x5 = (x3 * x2) >> 30;
        x7 = (x5 * x2) >> 30;
        return x - x3 / 6 + x5 / 120 - x7 / 5040;
    endfunction

    function automatic logic [15:0] centred_duty(longint t0, longint x);
        longint d2;
        d2 = t0 + 2 * x;
        if (d2 < 0) d2 = 0;
        if (d2 > 65536) d2 = 65536;
        return 16'(d2 >>> 1);
    endfunction

    function automatic t_duty predict_duties(t_req r);
        t_duty d;
        longint a, b, t0, t1, t2, xa, xb, xc;
        longint unsigned bus, y, m, c, p, sec, pos;
        a   = longint'(r.v_alpha);
        b   = longint'(r.v_beta);
        bus = 64'(r.bus_voltage);
        y   = 3 * longint'(a * a + b * b);
        if (bus == 0 || square_fits(32768 * bus, y)) begin
            m = 32768;
        end else begin
            m = 0;
            for (int bit_i = 14; bit_i >= 0; bit_i--) begin
                c = m | (64'd1 << bit_i);
                if (square_fits(c * bus, y)) m = c;
            end
        end
        p   = 64'(r.angle) * 6;
        sec = p >> 16;
        pos = p & 64'hFFFF;
        t2  = longint'((m * sine_q30(pos)) >> 30);
        t1  = longint'((m * sine_q30(65536 - pos)) >> 30);
        t0  = 32768 - t1 - t2;
        case (3'(sec))
            SEC_0: begin xa = t1 + t2; xb = t2;      xc = 0;       end
            SEC_1: begin xa = t1;      xb = t1 + t2; xc = 0;       end
            SEC_2: begin xa = 0;       xb = t1 + t2; xc = t2;      end
            SEC_3: begin xa = 0;       xb = t1;      xc = t1 + t2; end
            SEC_4: begin xa = t2;      xb = 0;       xc = t1 + t2; end
            default: begin xa = t1 + t2; xb = 0;     xc = t1;      end
        endcase
        d.sector    = 3'(sec);
        d.mod_index = 16'(m);
        d.a_hi      = centred_duty(t0, xa);
        d.b_hi      = centred_duty(t0, xb);
        d.c_hi      = centred_duty(t0, xc);
        d.a_lo      = Q15_ONE - d.a_hi;
        d.b_lo      = Q15_ONE - d.b_hi;
        d.c_lo      = Q15_ONE - d.c_hi;
        return d;
    endfunction

    function automatic t_req make_req(int va, int vb, int ang, int bus);
        t_req r;
        r.v_alpha     = 16'(va);
        r.v_beta      = 16'(vb);
        r.angle       = 16'(ang);
        r.bus_voltage = 16'(bus);
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int   mag;
        r.angle = 16'($urandom);
        case ($urandom_range(0, 9))
            0: r = make_req($urandom, $urandom, $urandom, $urandom);
            1: r = make_req($urandom, $urandom, $urandom, $urandom_range(0, 3));
            default: begin
                // mostly sensible vectors: magnitude below the bus level
                r.bus_voltage = 16'($urandom_range(1, 65535));
                mag = $urandom_range(0, 65535) % (int'(r.bus_voltage) / 2 + 1);
                if (mag > 32767) mag = 32767;
                r.v_alpha = 16'($urandom_range(0, mag) * ($urandom_range(0, 1) ? 1 : -1));
                r.v_beta  = 16'($urandom_range(0, mag) * ($urandom_range(0, 1) ? 1 : -1));
                r.angle   = 16'($urandom);
            end
        endcase
        return r;
    endfunction

    // request driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) n_sent <= n_sent + 1;
            if (!req_if.valid || req_if.ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    t_req r;
                    r = pending_reqs.pop_front();
                    expected_duties.push_back(predict_duties(r));
                    req_if.v_alpha     <= r.v_alpha;
                    req_if.v_beta      <= r.v_beta;
                    req_if.angle       <= r.angle;
                    req_if.bus_voltage <= r.bus_voltage;
                    req_if.valid       <= 1'b1;
                    if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                        src_gap <= $urandom_range(1, 4);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and sink stalls
    int snk_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_duties.size() == 0) begin
                    $error("result with no request outstanding");
                    n_errors <= n_errors + 1;
                end else begin
                    t_duty e;
                    int    bad;
                    e = expected_duties.pop_front();
                    bad = 0;
                    if (res_if.sector != e.sector) begin
                        $error("sector exp %0d got %0d", e.sector, res_if.sector); bad++;
                    end
                    if (res_if.mod_index != e.mod_index) begin
                        $error("mod_index exp %0d got %0d", e.mod_index, res_if.mod_index);
                        bad++;
                    end
                    if (res_if.duty_a_high != e.a_hi) begin
                        $error("duty_a_high exp %0d got %0d", e.a_hi, res_if.duty_a_high);
                        bad++;
                    end
                    if (res_if.duty_a_low != e.a_lo) begin
                        $error("duty_a_low exp %0d got %0d", e.a_lo, res_if.duty_a_low);
                        bad++;
                    end
                    if (res_if.duty_b_high != e.b_hi) begin
                        $error("duty_b_high exp %0d got %0d", e.b_hi, res_if.duty_b_high);
                        bad++;
                    end
                    if (res_if.duty_b_low != e.b_lo) begin
                        $error("duty_b_low exp %0d got %0d", e.b_lo, res_if.duty_b_low);
                        bad++;
                    end
                    if (res_if.duty_c_high != e.c_hi) begin
                        $error("duty_c_high exp %0d got %0d", e.c_hi, res_if.duty_c_high);
                        bad++;
                    end
                    if (res_if.duty_c_low != e.c_lo) begin
                        $error("duty_c_low exp %0d got %0d", e.c_lo, res_if.duty_c_low);
                        bad++;
                    end
                    n_errors  <= n_errors + bad;
                    n_checked <= n_checked + 1;
                end
            end
            if (hold_active) begin
                res_if.ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                res_if.ready <= 1'b0;
            end else if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                snk_gap <= $urandom_range(0, 3);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the pipe fills and back-pressures the input
    initial begin
        wait (n_sent >= 40);
        @(posedge i_clk);
        hold_active = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_active = 1'b0;
    end

    // stimulus and end of run
    initial begin
        req_if.valid = 1'b0;
        req_if.v_alpha = '0;
        req_if.v_beta = '0;
        req_if.angle = '0;
        req_if.bus_voltage = '0;
        res_if.ready = 1'b0;
        // directed corners: zero bus, zero vector, saturation, extremes, sectors
        pending_reqs.push_back(make_req(0, 0, 0, 0));
        pending_reqs.push_back(make_req(100, -50, 12345, 0));
        pending_reqs.push_back(make_req(0, 0, 0, 65535));
        pending_reqs.push_back(make_req(-32768, -32768, 65535, 65535));
        pending_reqs.push_back(make_req(32767, 32767, 32768, 1));
        pending_reqs.push_back(make_req(-32768, 32767, 1, 65535));
        pending_reqs.push_back(make_req(32767, -32768, 10923, 65535));
        pending_reqs.push_back(make_req(1, 0, 0, 65535));
        for (int s = 0; s < 6; s++) begin
            pending_reqs.push_back(make_req(8000, 6000, s * 10923, 40000));
            pending_reqs.push_back(make_req(-9000, 3000, s * 10923 + 10922, 30000));
        end
        pending_reqs.push_back(make_req(20000, 20000, 5461, 30000));
        pending_reqs.push_back(make_req(0, 32767, 16384, 56755));
        pending_reqs.push_back(make_req(16384, 0, 65535, 65535));
        for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(random_req());
        n_total = pending_reqs.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_sent == n_total && expected_duties.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("ran %0d requests (directed corners, random vectors), %0d results checked",
                 n_total, n_checked);
        $display("with random stalls on both sides and one long result hold-off");
        if (n_errors == 0 && expected_duties.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/svpd_pkg.sv
hw/rtl/svpd_in_if.sv
hw/rtl/svpd_out_if.sv
hw/rtl/space_vector_pwm_duty_core.sv
tb/space_vector_pwm_duty_core_tb.sv
